[rtl/dkrh_pkg.sv]
// Package for the DNA k-mer rolling hash block.
// Holds the beat types, register codes, seed table and rotate helpers.
// No dependencies.
package dkrh_pkg;

  localparam int unsigned HashW   = 64;
  localparam int unsigned KW      = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [KW-1:0] FillMax = 6'd63;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KMER_LENGTH = 2'd0,
    REG_HPC_ENABLE  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] base;
    logic       new_sequence;
  } in_beat_t;

  typedef struct packed {
    logic [HashW-1:0] forward_hash;
    logic [HashW-1:0] rc_hash;
    logic             window_full;
  } out_beat_t;

  function automatic logic [HashW-1:0] seed(input logic [1:0] b);
    logic [HashW-1:0] s;
    unique case (b)
      2'd0: s = 64'h3c8bfbb395c60474;
      2'd1: s = 64'h3193c18562a02b4c;
      2'd2: s = 64'h20323ed082572324;
      default: s = 64'h295549f54be24456;
    endcase
    return s;
  endfunction

  function automatic logic [HashW-1:0] rol64(input logic [HashW-1:0] x,
                                             input logic [KW-1:0] n);
    logic [6:0] m;
    m = 7'd64 - {1'b0, n};
    return (x << n) | (x >> m);
  endfunction

  function automatic logic [HashW-1:0] ror1(input logic [HashW-1:0] x);
    return {x[0], x[HashW-1:1]};
  endfunction

  function automatic logic [HashW-1:0] rol1(input logic [HashW-1:0] x);
    return {x[HashW-2:0], x[HashW-1]};
  endfunction

endpackage

[rtl/dkrh_cell.sv]
// One window cell: holds one base and passes it to the next cell on shift.
// Depends on nothing.
module dkrh_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [1:0] d_i,
  output logic [1:0] q_o
);

  logic [1:0] base_q;
  logic [1:0] base_d;

  assign base_d = en_i ? d_i : base_q;

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  assign q_o = base_q;

endmodule

[rtl/dkrh_window.sv]
// Base window: a chain of dkrh_cell instances with a selectable tap.
// Depends on dkrh_cell.
module dkrh_window #(
  parameter int unsigned MAX_K = 63,
  parameter int unsigned IdxW  = 6
) (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic [1:0]      base_i,
  input  logic [IdxW-1:0] tap_i,
  output logic [1:0]      tap_o
);

  logic [1:0] cell_q [MAX_K];

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    logic [1:0] cell_d;
    if (g == 0) begin : g_head
      assign cell_d = base_i;
    end else begin : g_link
      assign cell_d = cell_q[g-1];
    end
    dkrh_cell u_cell (
      .clk_i (clk_i),
      .en_i  (shift_i),
      .d_i   (cell_d),
      .q_o   (cell_q[g])
    );
  end

  assign tap_o = cell_q[tap_i];

endmodule

[rtl/dna_kmer_rolling_hash_top.sv]
// Result beats go to a two-entry output buffer that decouples stall: the output
// entry, or the skid entry if output stalls. Throughput: one base per cycle
// while in_stall_o is low; window and both hashes update in the accept cycle.
// A base dropped by homopolymer compression gives no result beat.
// Reset (rst_ni low, async) clears hashes, fill count, history and buffers;
// kmer_length returns to 31 and hpc_enable to 0.
module dna_kmer_rolling_hash_top #(
  parameter int unsigned MAX_K = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dkrh_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dkrh_pkg::out_beat_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dkrh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dkrh_pkg::CfgDataW-1:0]  cfg_data_i
);

  import dkrh_pkg::*;

  localparam int unsigned IdxW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam logic [KW-1:0] MaxK = KW'(MAX_K);

  logic [KW-1:0]    kmer_length_q, kmer_length_d;
  logic             hpc_enable_q, hpc_enable_d;
  logic [HashW-1:0] fwd_q, fwd_d, rev_q, rev_d;
  logic [KW-1:0]    fill_q, fill_d;
  logic [1:0]       prev_base_q, prev_base_d;
  logic             prev_valid_q, prev_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  out_beat_t        out_q, out_d, skid_q, skid_d;

  logic             in_fire, out_fire, drop, take, start, full_before;
  logic [KW-1:0]    k_w, fill_base, fill_new;
  logic [HashW-1:0] fwd_base, rev_base, out_fwd, out_rev;
  logic [1:0]       tap;
  out_beat_t        res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    kmer_length_d = kmer_length_q;
    hpc_enable_d  = hpc_enable_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KMER_LENGTH: kmer_length_d = cfg_data_i[KW-1:0];
        REG_HPC_ENABLE:  hpc_enable_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kmer_length_q == '0) begin
      k_w = KW'(1);
    end else if (kmer_length_q > MaxK) begin
      k_w = MaxK;
    end else begin
      k_w = kmer_length_q;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign start      = in_data_i.new_sequence;

  assign fwd_base  = start ? '0 : fwd_q;
  assign rev_base  = start ? '0 : rev_q;
  assign fill_base = start ? '0 : fill_q;
  assign drop      = hpc_enable_q && !start && prev_valid_q
                     && (in_data_i.base == prev_base_q);
  assign take      = in_fire && !drop;

  dkrh_window #(
    .MAX_K (MAX_K),
    .IdxW  (IdxW)
  ) u_window (
    .clk_i   (clk_i),
    .shift_i (take),
    .base_i  (in_data_i.base),
    .tap_i   (IdxW'(k_w - KW'(1))),
    .tap_o   (tap)
  );

  assign full_before = fill_base >= k_w;
  assign out_fwd = full_before ? rol64(seed(tap), k_w) : '0;
  assign out_rev = full_before ? ror1(seed(2'd3 - tap)) : '0;
  assign fill_new = (fill_base == FillMax) ? fill_base : fill_base + KW'(1);

  always_comb begin
    fwd_d        = fwd_q;
    rev_d        = rev_q;
    fill_d       = fill_q;
    prev_base_d  = prev_base_q;
    prev_valid_d = prev_valid_q;
    if (take) begin
      fwd_d        = rol1(fwd_base) ^ out_fwd ^ seed(in_data_i.base);
      rev_d        = ror1(rev_base) ^ out_rev
                     ^ rol64(seed(2'd3 - in_data_i.base), k_w - KW'(1));
      fill_d       = fill_new;
      prev_base_d  = in_data_i.base;
      prev_valid_d = 1'b1;
    end
  end

  assign res.forward_hash = fwd_d;
  assign res.rc_hash      = rev_d;
  assign res.window_full  = fill_new >= k_w;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (take) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KW'(31);
      hpc_enable_q  <= 1'b0;
      fwd_q         <= '0;
      rev_q         <= '0;
      fill_q        <= '0;
      prev_base_q   <= '0;
      prev_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      kmer_length_q <= kmer_length_d;
      hpc_enable_q  <= hpc_enable_d;
      fwd_q         <= fwd_d;
      rev_q         <= rev_d;
      fill_q        <= fill_d;
      prev_base_q   <= prev_base_d;
      prev_valid_q  <= prev_valid_d;
      out_valid_q   <= out_valid_d;
      skid_valid_q  <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("taken base produced no result beat");

  a_drop_holds_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && drop) |=> ($stable(fwd_q) && $stable(rev_q) && $stable(fill_q)))
    else $error("dropped base changed hash state");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !start) |=> (fill_q >= $past(fill_q)))
    else $error("fill count fell within a sequence");

endmodule
